// ----- hw/rtl/pmf_pkg.sv -----
// pmf_pkg: shared types, constants and the tile phase function
// for the pixelate mosaic filter; no dependencies
package pmf_pkg;

  localparam int MaxWidthDefault = 2048;
  localparam int ColorW = 24;
  localparam logic [7:0] BlockSizeReset = 8'd1;

  typedef enum logic [1:0] {
    SEL_HELD,
    SEL_PIXEL,
    SEL_STORE
  } color_sel_t;

  typedef struct packed {
    logic       we;
    logic       re;
    color_sel_t sel;
  } tile_req_t;

  function automatic logic [7:0] next_phase(input logic [7:0] phase, input logic [7:0] size);
    logic [8:0] n;
    n = {1'b0, phase} + 9'd1;
    return (n >= {1'b0, size} || n[8]) ? 8'd0 : n[7:0];
  endfunction

endpackage

// ----- hw/rtl/pmf_ram.sv -----
// pmf_ram: generic single-port synchronous ram with registered read
// no dependencies
module pmf_ram #(
  parameter int Width = 24,
  parameter int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AddrW-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hw/rtl/pmf_tile_ctrl.sv -----
// pmf_tile_ctrl: column and tile phase counters, row store addressing
// depends on pmf_pkg
module pmf_tile_ctrl #(
  parameter int MaxWidth = pmf_pkg::MaxWidthDefault,
  localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          block_size,
  input  logic                accept,
  input  logic                frame_start,
  input  logic                line_end,
  output pmf_pkg::tile_req_t  req,
  output logic [ColW-1:0]     addr
);
  import pmf_pkg::*;

  localparam logic [ColW-1:0] ColMax = ColW'(MaxWidth - 1);

  logic [ColW-1:0] column;
  logic [7:0]      column_phase;
  logic [7:0]      row_phase;
  logic [ColW-1:0] col_e;
  logic [7:0]      cp_e;
  logic [7:0]      rp_e;
  logic            tile_start;

  always_comb begin
    col_e = frame_start ? '0 : column;
    cp_e = frame_start ? 8'd0 : column_phase;
    rp_e = frame_start ? 8'd0 : row_phase;
    tile_start = (cp_e == 8'd0);
    req.we = accept && tile_start && (rp_e == 8'd0);
    req.re = accept && tile_start && (rp_e != 8'd0);
    if (!tile_start) begin
      req.sel = SEL_HELD;
    end else if (rp_e == 8'd0) begin
      req.sel = SEL_PIXEL;
    end else begin
      req.sel = SEL_STORE;
    end
    addr = col_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      column_phase <= 8'd0;
      row_phase <= 8'd0;
    end else if (accept) begin
      if (line_end) begin
        column <= '0;
        column_phase <= 8'd0;
        row_phase <= next_phase(rp_e, block_size);
      end else begin
        column <= (col_e == ColMax) ? ColMax : col_e + ColW'(1);
        column_phase <= next_phase(cp_e, block_size);
        row_phase <= rp_e;
      end
    end
  end

endmodule

// ----- hw/rtl/pixelate_mosaic_filter_unit.sv -----
// pixelate_mosaic_filter_unit: top level of the pixelate mosaic filter
// depends on pmf_pkg, pmf_tile_ctrl and pmf_ram
//
// Input words carry one RGB pixel in raster order with frame_start and
// line_end flags; output words carry the mosaic pixel and a copy of
// line_end. Both channels use valid/ready. Each pixel is replaced by the
// top-left pixel of its block_size by block_size tile. On the first row of
// a tile band the tile start color is written to a row store of MaxWidth
// entries; later rows read it back through the registered ram read.
// An accepted word passes through the read stage register and then the
// output register. Throughput: one word per cycle while out_ready holds;
// the row store sees at most one access (read or write) per accepted word.
// A stalled receiver holds the output register; one more word can sit in
// the read stage, after which in_ready drops until the output drains.
// Reset empties the pipeline, holds in_ready low, zeroes the counters and
// the held color and sets block_size to 1. The row store is not cleared;
// block_size is written through cfg_write/cfg_data; the user must write
// it only while the block is idle, which the block does not enforce.
module pixelate_mosaic_filter_unit #(
  parameter int MaxWidth = pmf_pkg::MaxWidthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       frame_start,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_line_end
);
  import pmf_pkg::*;

  localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

  logic [7:0]        block_size;
  logic              accept;
  logic              s1_advance;
  tile_req_t         req;
  logic [ColW-1:0]   addr;
  logic [ColorW-1:0] pixel;
  logic [ColorW-1:0] rdata;

  logic              s1_valid;
  color_sel_t        s1_sel;
  logic [ColorW-1:0] s1_pixel;
  logic              s1_line_end;
  logic [ColorW-1:0] s1_color;
  logic [ColorW-1:0] held_color;

  assign pixel = {red, green, blue};
  assign s1_advance = !out_valid || out_ready;
  assign in_ready = !rst && (!s1_valid || s1_advance);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BlockSizeReset;
    end else if (cfg_write) begin
      block_size <= cfg_data;
    end
  end

  pmf_tile_ctrl #(
    .MaxWidth(MaxWidth)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .block_size (block_size),
    .accept     (accept),
    .frame_start(frame_start),
    .line_end   (line_end),
    .req        (req),
    .addr       (addr)
  );

  pmf_ram #(
    .Width(ColorW),
    .Depth(MaxWidth)
  ) u_row_store (
    .clk  (clk),
    .we   (req.we),
    .re   (req.re),
    .addr (addr),
    .wdata(pixel),
    .rdata(rdata)
  );

  always_comb begin
    case (s1_sel)
      SEL_HELD:  s1_color = held_color;
      SEL_PIXEL: s1_color = s1_pixel;
      SEL_STORE: s1_color = rdata;
      default:   s1_color = held_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      held_color <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          held_color <= s1_color;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sel <= req.sel;
      s1_pixel <= pixel;
      s1_line_end <= line_end;
    end
    if (s1_advance && s1_valid) begin
      out_red <= s1_color[23:16];
      out_green <= s1_color[15:8];
      out_blue <= s1_color[7:0];
      out_line_end <= s1_line_end;
    end
  end

  // a store read is queued behind the word that asked for it
  assert property (@(posedge clk) disable iff (rst)
    req.re |=> s1_valid && s1_sel == SEL_STORE)
    else $error("store read not followed by store select");

  // read data must hold while the read stage is stalled
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> $stable(rdata))
    else $error("row store read data changed under stall");

  assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re))
    else $error("row store read and write in one cycle");

  assert property (@(posedge clk) disable iff (rst)
    (req.we || req.re) |-> accept)
    else $error("row store access without accepted word");

  assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

endmodule
